/* rtl/dtpl_pkg.sv */
// Shared types and constants for the digit trie prefix lookup block.
package dtpl_pkg;

    localparam int MAX_NODES    = 4096;
    localparam int MAX_RECORDS  = 1024;
    localparam int MAX_DIGITS   = 15;
    localparam int NODE_W       = $clog2(MAX_NODES);
    localparam int REC_W        = $clog2(MAX_RECORDS);
    localparam int CHILD_DEPTH  = MAX_NODES * 10;
    localparam int CHILD_AW     = $clog2(CHILD_DEPTH);
    localparam int LINK_W       = 13;
    localparam int NCOUNT_W     = 13;
    localparam int RCOUNT_W     = 11;
    localparam int CFG_W        = 13;
    localparam int OFF_W        = 21;
    localparam int CNT_W        = 5;
    localparam int IDX_W        = 12;
    localparam int DIG_W        = 4;

    localparam logic [1:0] CMD_CHILD  = 2'd0;
    localparam logic [1:0] CMD_NODE   = 2'd1;
    localparam logic [1:0] CMD_RECORD = 2'd2;
    localparam logic [1:0] CMD_LOOKUP = 2'd3;

    localparam logic [1:0] STATUS_FOUND   = 2'd0;
    localparam logic [1:0] STATUS_NO_DATA = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    localparam logic CFG_NODE_LIMIT = 1'b0;
    localparam logic CFG_REC_LIMIT  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHILD,
        S_LINK,
        S_REC,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic child_eval;
        logic link_eval;
        logic rec_update;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_go;
        logic child_ok;
        logic link_ok;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/dtpl_ctrl.sv */
// Controller state machine that sequences memory loads and the trie walk.
module dtpl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_cmd,
    input  logic                 i_last,
    input  dtpl_pkg::t_dp_status i_status,
    output dtpl_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_stall
);

    dtpl_pkg::t_state r_state;
    dtpl_pkg::t_state n_state;
    logic             r_last;
    logic             n_last;
    logic             accept;

    assign accept = i_in_valid && (r_state == dtpl_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtpl_pkg::S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        case (r_state)
            dtpl_pkg::S_IDLE: begin
                if (accept && (i_cmd == dtpl_pkg::CMD_LOOKUP)) begin
                    n_last = i_last;
                    if (i_status.walk_go) begin
                        n_state = dtpl_pkg::S_CHILD;
                    end else if (i_last) begin
                        n_state = dtpl_pkg::S_EMIT;
                    end
                end
            end
            dtpl_pkg::S_CHILD: begin
                if (i_status.child_ok) begin
                    n_state = dtpl_pkg::S_LINK;
                end else begin
                    n_state = r_last ? dtpl_pkg::S_EMIT : dtpl_pkg::S_IDLE;
                end
            end
            dtpl_pkg::S_LINK: begin
                if (i_status.link_ok) begin
                    n_state = dtpl_pkg::S_REC;
                end else begin
                    n_state = r_last ? dtpl_pkg::S_EMIT : dtpl_pkg::S_IDLE;
                end
            end
            dtpl_pkg::S_REC: begin
                n_state = r_last ? dtpl_pkg::S_EMIT : dtpl_pkg::S_IDLE;
            end
            dtpl_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = dtpl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dtpl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            dtpl_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = accept;
            end
            dtpl_pkg::S_CHILD: begin
                o_cmd.child_eval = 1'b1;
            end
            dtpl_pkg::S_LINK: begin
                o_cmd.link_eval = 1'b1;
            end
            dtpl_pkg::S_REC: begin
                o_cmd.rec_update = 1'b1;
            end
            dtpl_pkg::S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/dtpl_dp.sv */
// Datapath: trie memories, walk registers, configuration and result register.
module dtpl_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dtpl_pkg::t_dp_cmd                   i_cmd_ctl,
    output dtpl_pkg::t_dp_status                o_status_dp,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [dtpl_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [1:0]                          i_cmd,
    input  logic [dtpl_pkg::IDX_W-1:0]          i_entry_index,
    input  logic [dtpl_pkg::DIG_W-1:0]          i_digit,
    input  logic signed [dtpl_pkg::LINK_W-1:0]  i_link,
    input  logic signed [dtpl_pkg::OFF_W-1:0]   i_city_offset,
    input  logic signed [dtpl_pkg::OFF_W-1:0]   i_region_offset,
    input  logic signed [dtpl_pkg::OFF_W-1:0]   i_zone_offset,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic signed [dtpl_pkg::OFF_W-1:0]   o_found_city,
    output logic signed [dtpl_pkg::OFF_W-1:0]   o_found_region,
    output logic signed [dtpl_pkg::OFF_W-1:0]   o_found_zone
);

    localparam int NW = dtpl_pkg::NODE_W;
    localparam int RW = dtpl_pkg::REC_W;
    localparam int AW = dtpl_pkg::CHILD_AW;
    localparam int OW = dtpl_pkg::OFF_W;

    // Memories. A record link entry keeps a flag for "never usable" and the index.
    logic [dtpl_pkg::LINK_W-1:0] child_mem [dtpl_pkg::CHILD_DEPTH];
    logic [RW:0]                 node_mem  [dtpl_pkg::MAX_NODES];
    logic [3*OW-1:0]             rec_mem   [dtpl_pkg::MAX_RECORDS];

    logic [dtpl_pkg::LINK_W-1:0] r_child_q;
    logic [RW:0]                 r_link_q;
    logic [3*OW-1:0]             r_rec_q;

    logic [dtpl_pkg::NCOUNT_W-1:0] r_node_limit;
    logic [dtpl_pkg::RCOUNT_W-1:0] r_rec_limit;

    logic [NW-1:0]           r_cur_node;
    logic                    r_stopped;
    logic [dtpl_pkg::CNT_W-1:0] r_count;
    logic [OW-1:0]           r_lat_city;
    logic [OW-1:0]           r_lat_region;
    logic [OW-1:0]           r_lat_zone;

    logic                    r_out_valid;
    logic [1:0]              r_out_status;
    logic [OW-1:0]           r_out_city;
    logic [OW-1:0]           r_out_region;
    logic [OW-1:0]           r_out_zone;

    logic          is_lookup;
    logic          digit_ok;
    logic [AW-1:0] walk_addr;
    logic [AW-1:0] wr_addr;
    logic          child_we;
    logic          node_we;
    logic          rec_we;
    logic          child_ok;
    logic          link_ok;
    logic          out_free;
    logic          too_long;
    logic          no_data;
    logic [RW:0]   link_enc;
    logic [OW-1:0] rec_city;
    logic [OW-1:0] rec_region;
    logic [OW-1:0] rec_zone;

    assign is_lookup = i_cmd_ctl.accept && (i_cmd == dtpl_pkg::CMD_LOOKUP);
    assign digit_ok  = (i_digit <= 4'd9);

    // Node times ten as two shifts and an add.
    assign walk_addr = AW'({r_cur_node, 3'b000}) + AW'({r_cur_node, 1'b0}) + AW'(i_digit);
    assign wr_addr   = AW'({i_entry_index[NW-1:0], 3'b000})
                     + AW'({i_entry_index[NW-1:0], 1'b0}) + AW'(i_digit);

    assign child_we = i_cmd_ctl.accept && (i_cmd == dtpl_pkg::CMD_CHILD) && digit_ok;
    assign node_we  = i_cmd_ctl.accept && (i_cmd == dtpl_pkg::CMD_NODE);
    assign rec_we   = i_cmd_ctl.accept && (i_cmd == dtpl_pkg::CMD_RECORD)
                   && (i_entry_index[dtpl_pkg::IDX_W-1:RW] == '0);

    // Negative links and links past the record table can never be used.
    assign link_enc = {i_link[dtpl_pkg::LINK_W-1]
                       || (i_link[dtpl_pkg::LINK_W-2:RW] != '0), i_link[RW-1:0]};

    // A nonnegative child link is below the node table size, so only the configured
    // node limit bounds it.
    assign child_ok = !r_child_q[dtpl_pkg::LINK_W-1]
                   && (dtpl_pkg::NCOUNT_W'(r_child_q[NW-1:0]) < r_node_limit);
    assign link_ok  = !r_link_q[RW]
                   && (dtpl_pkg::RCOUNT_W'(r_link_q[RW-1:0]) < r_rec_limit);

    assign rec_city   = r_rec_q[3*OW-1:2*OW];
    assign rec_region = r_rec_q[2*OW-1:OW];
    assign rec_zone   = r_rec_q[OW-1:0];

    assign out_free = !r_out_valid || !i_out_stall;
    assign too_long = (r_count > dtpl_pkg::CNT_W'(dtpl_pkg::MAX_DIGITS));
    assign no_data  = (&r_lat_city) && (&r_lat_region) && (&r_lat_zone);

    assign o_status_dp.walk_go  = is_lookup && !r_stopped && digit_ok;
    assign o_status_dp.child_ok = child_ok;
    assign o_status_dp.link_ok  = link_ok;
    assign o_status_dp.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (child_we) begin
            child_mem[wr_addr] <= i_link;
        end
        r_child_q <= child_mem[walk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[i_entry_index[NW-1:0]] <= link_enc;
        end
        r_link_q <= node_mem[r_child_q[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[i_entry_index[RW-1:0]] <= {i_city_offset, i_region_offset, i_zone_offset};
        end
        if (i_cmd_ctl.link_eval) begin
            r_rec_q <= rec_mem[r_link_q[RW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_limit <= dtpl_pkg::NCOUNT_W'(1);
            r_rec_limit  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dtpl_pkg::CFG_NODE_LIMIT) begin
                r_node_limit <= i_cfg_data;
            end else begin
                r_rec_limit <= i_cfg_data[dtpl_pkg::RCOUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_node   <= '0;
            r_stopped    <= 1'b0;
            r_count      <= '0;
            r_lat_city   <= '1;
            r_lat_region <= '1;
            r_lat_zone   <= '1;
        end else if (i_cmd_ctl.emit) begin
            r_cur_node   <= '0;
            r_stopped    <= 1'b0;
            r_count      <= '0;
            r_lat_city   <= '1;
            r_lat_region <= '1;
            r_lat_zone   <= '1;
        end else begin
            if (is_lookup) begin
                if (!(&r_count)) begin
                    r_count <= r_count + 1'b1;
                end
                if (!digit_ok) begin
                    r_stopped <= 1'b1;
                end
            end
            if (i_cmd_ctl.child_eval) begin
                if (child_ok) begin
                    r_cur_node <= r_child_q[NW-1:0];
                end else begin
                    r_stopped <= 1'b1;
                end
            end
            if (i_cmd_ctl.rec_update) begin
                if (!(&rec_city)) begin
                    r_lat_city <= rec_city;
                end
                if (!(&rec_region)) begin
                    r_lat_region <= rec_region;
                end
                if (!(&rec_zone)) begin
                    r_lat_zone <= rec_zone;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.emit) begin
            if (too_long) begin
                r_out_status <= dtpl_pkg::STATUS_TOO_LONG;
                r_out_city   <= '1;
                r_out_region <= '1;
                r_out_zone   <= '1;
            end else if (no_data) begin
                r_out_status <= dtpl_pkg::STATUS_NO_DATA;
                r_out_city   <= '1;
                r_out_region <= '1;
                r_out_zone   <= '1;
            end else begin
                r_out_status <= dtpl_pkg::STATUS_FOUND;
                r_out_city   <= r_lat_city;
                r_out_region <= r_lat_region;
                r_out_zone   <= r_lat_zone;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_city   = r_out_city;
    assign o_found_region = r_out_region;
    assign o_found_zone   = r_out_zone;

endmodule

/* rtl/digit_trie_prefix_lookup_core.sv */
// Top level of the digit trie longest-prefix lookup block.
//
//   channel   direction   handshake                 payload
//   in        input       i_in_valid / o_in_stall   cmd, entry_index, digit, link, offsets, last
//   out       output      o_out_valid / i_out_stall status, found_city/region/zone
//   cfg       input       i_cfg_we                  i_cfg_index, i_cfg_data
//
// A write command is accepted in IDLE. A digit goes on from IDLE through CHILD, LINK and REC
// until the walk stops: the child read, the record link read and the record read are dependent
// accesses to three memories, each with a registered read. The last digit then goes to EMIT to
// load the result register, and waits there while a stalled result is still held.
// Reset is synchronous; memories are not cleared and need no clearing pass.
module digit_trie_prefix_lookup_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [dtpl_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic [dtpl_pkg::IDX_W-1:0]          i_entry_index,
    input  logic [dtpl_pkg::DIG_W-1:0]          i_digit,
    input  logic signed [dtpl_pkg::LINK_W-1:0]  i_link,
    input  logic signed [dtpl_pkg::OFF_W-1:0]   i_city_offset,
    input  logic signed [dtpl_pkg::OFF_W-1:0]   i_region_offset,
    input  logic signed [dtpl_pkg::OFF_W-1:0]   i_zone_offset,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic signed [dtpl_pkg::OFF_W-1:0]   o_found_city,
    output logic signed [dtpl_pkg::OFF_W-1:0]   o_found_region,
    output logic signed [dtpl_pkg::OFF_W-1:0]   o_found_zone
);

    dtpl_pkg::t_dp_cmd    dp_cmd;
    dtpl_pkg::t_dp_status dp_status;

    dtpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_last     (i_last),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    dtpl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_ctl       (dp_cmd),
        .o_status_dp     (dp_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_entry_index   (i_entry_index),
        .i_digit         (i_digit),
        .i_link          (i_link),
        .i_city_offset   (i_city_offset),
        .i_region_offset (i_region_offset),
        .i_zone_offset   (i_zone_offset),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_found_city    (o_found_city),
        .o_found_region  (o_found_region),
        .o_found_zone    (o_found_zone)
    );

endmodule
